@@ src/smx_pkg.sv @@
// ----------------------------------------------------------------------------
// smx_pkg - shared definitions for the stack machine executor
// Opcode and fault codes, field widths, default sizes and FSM states.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int KIND_W  = 4;
  localparam int OPND_W  = 8;
  localparam int WORD_W  = 32;
  localparam int NPC_W   = 16;
  localparam int FAULT_W = 2;

  localparam int DIV_CNT_W = $clog2(WORD_W);

  // in_tdata carries the operand, padded to a whole byte
  localparam int IN_TDATA_W  = ((OPND_W + 7) / 8) * 8;
  // out_tdata: next_pc, print_value, halted, fault
  localparam int OUT_FIELD_W = NPC_W + WORD_W + 1 + FAULT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int PC_BITS_DEF     = 16;

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_EQ    = 4'd5,
    OP_JZ    = 4'd6,
    OP_PRINT = 4'd7,
    OP_HALT  = 4'd8
  } op_t;

  typedef enum logic [FAULT_W-1:0] {
    FLT_NONE = 2'd0,
    FLT_UNDF = 2'd1,
    FLT_OVFL = 2'd2,
    FLT_DIV  = 2'd3
  } fault_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_DFIN
  } state_t;

endpackage

@@ src/stack_machine_executor_unit.sv @@
// ----------------------------------------------------------------------------
// stack_machine_executor_unit - stack machine instruction executor
// Executes one decoded instruction per request against a stack memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_tuser is the opcode kind, in_tdata the immediate byte.
//   Result channel: one result per instruction, next_pc/print_value/halted/
//   fault in out_tdata and the print flag in out_tuser.
//   The operand stack lives in a synchronous memory with two read ports and
//   one write port. An accepted request reads the top two entries; the next
//   cycle computes and writes back, loading the output register.
//   out_tvalid rises once the execute state loads the output register; a
//   divide first passes execute, a 32-step restoring divider and a
//   sign-fixing state. Requests are taken only while idle, so a divide
//   holds the block until done; stack read-compute-writeback sets this.
//   A new request is taken while the previous result is being handed over.
//   Receiver stall: the result waits in the output register and no further
//   request is taken until it is gone.
//   Reset clears stack depth, pc and halt mark; stack contents are undefined.
// ----------------------------------------------------------------------------
module stack_machine_executor_unit #(
  parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
  parameter int PC_BITS     = smx_pkg::PC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [smx_pkg::IN_TDATA_W-1:0] in_tdata,  // [7:0] operand
  input  logic [smx_pkg::KIND_W-1:0]     in_tuser,  // [3:0] kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] next_pc, [47:16] print_value, [48] halted, [50:49] fault, rest 0
  output logic [smx_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tuser  // [0] print_valid
);
  import smx_pkg::*;

  localparam int AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

  // stack memory
  logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     rd_top_addr;
  logic [AW-1:0]     rd_sec_addr;
  logic [WORD_W-1:0] stk_top_r;
  logic [WORD_W-1:0] stk_sec_r;

  // control state
  state_t               state_r, state_nxt;
  logic [DEPTH_W-1:0]   depth_r, depth_nxt;
  logic [PC_BITS-1:0]   pc_r, pc_nxt;
  logic                 halt_r, halt_nxt;
  logic [KIND_W-1:0]    kind_r;
  logic [OPND_W-1:0]    opnd_r;

  // divider
  logic [WORD_W-1:0]    div_rem_r, div_rem_nxt;
  logic [WORD_W-1:0]    div_quo_r, div_quo_nxt;
  logic [WORD_W-1:0]    div_den_r, div_den_nxt;
  logic                 div_neg_r, div_neg_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [WORD_W:0]      div_sh;
  logic [WORD_W:0]      div_diff;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [NPC_W-1:0]     o_npc_r, o_npc_nxt;
  logic                 o_pvalid_r, o_pvalid_nxt;
  logic [WORD_W-1:0]    o_pvalue_r, o_pvalue_nxt;
  logic                 o_halted_r, o_halted_nxt;
  fault_t               o_fault_r, o_fault_nxt;

  logic                 in_acc;
  logic [PC_BITS-1:0]   pc_inc;
  logic                 load_out;
  logic [WORD_W-1:0]    mag_a, mag_b;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  assign rd_top_addr = AW'(depth_r - DEPTH_W'(1));
  assign rd_sec_addr = AW'(depth_r - DEPTH_W'(2));

  assign mag_a = stk_sec_r[WORD_W-1] ? (~stk_sec_r + WORD_W'(1)) : stk_sec_r;
  assign mag_b = stk_top_r[WORD_W-1] ? (~stk_top_r + WORD_W'(1)) : stk_top_r;

  // one restoring division step
  assign div_sh   = {div_rem_r, div_quo_r[WORD_W-1]};
  assign div_diff = div_sh - {1'b0, div_den_r};

  // push and jz are two-byte instructions
  assign pc_inc = ((op_t'(kind_r) == OP_PUSH) || (op_t'(kind_r) == OP_JZ)) ?
                  PC_BITS'(2) : PC_BITS'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      stk_top_r <= stack_mem[rd_top_addr];
      stk_sec_r <= stack_mem[rd_sec_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    pc_nxt        = pc_r;
    halt_nxt      = halt_r;
    div_rem_nxt   = div_rem_r;
    div_quo_nxt   = div_quo_r;
    div_den_nxt   = div_den_r;
    div_neg_nxt   = div_neg_r;
    div_cnt_nxt   = div_cnt_r;
    mem_we        = 1'b0;
    mem_waddr     = AW'(depth_r);
    mem_wdata     = WORD_W'(opnd_r);
    load_out      = 1'b0;
    o_pvalid_nxt  = 1'b0;
    o_pvalue_nxt  = '0;
    o_fault_nxt   = FLT_NONE;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_IDLE;
        load_out  = 1'b1;
        if (!halt_r) begin
          pc_nxt = pc_r + pc_inc;
          unique case (op_t'(kind_r))
            OP_PUSH: begin
              if (depth_r == DEPTH_W'(STACK_DEPTH)) begin
                o_fault_nxt = FLT_OVFL;
              end else begin
                mem_we    = 1'b1;
                depth_nxt = depth_r + DEPTH_W'(1);
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ: begin
              mem_waddr = rd_sec_addr;
              if (depth_r < DEPTH_W'(2)) begin
                o_fault_nxt = FLT_UNDF;
              end else if (op_t'(kind_r) == OP_DIV) begin
                if (stk_top_r == '0) begin
                  o_fault_nxt = FLT_DIV;
                end else begin
                  // start divider on magnitudes; result held back until done
                  load_out    = 1'b0;
                  pc_nxt      = pc_r;
                  state_nxt   = S_DIV;
                  div_rem_nxt = '0;
                  div_quo_nxt = mag_a;
                  div_den_nxt = mag_b;
                  div_neg_nxt = stk_sec_r[WORD_W-1] ^ stk_top_r[WORD_W-1];
                  div_cnt_nxt = '0;
                end
              end else begin
                mem_we    = 1'b1;
                depth_nxt = depth_r - DEPTH_W'(1);
                case (op_t'(kind_r))
                  OP_ADD:  mem_wdata = stk_sec_r + stk_top_r;
                  OP_SUB:  mem_wdata = stk_sec_r - stk_top_r;
                  OP_MUL:  mem_wdata = stk_sec_r * stk_top_r;
                  default: mem_wdata = WORD_W'(stk_sec_r == stk_top_r);
                endcase
              end
            end
            OP_JZ, OP_PRINT: begin
              if (depth_r == '0) begin
                o_fault_nxt = FLT_UNDF;
              end else begin
                depth_nxt = depth_r - DEPTH_W'(1);
                if (op_t'(kind_r) == OP_PRINT) begin
                  o_pvalid_nxt = 1'b1;
                  o_pvalue_nxt = stk_top_r;
                end else if (stk_top_r == '0) begin
                  pc_nxt = PC_BITS'(opnd_r);
                end
              end
            end
            OP_HALT: begin
              halt_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      S_DIV: begin
        div_rem_nxt = div_diff[WORD_W] ? div_sh[WORD_W-1:0] : div_diff[WORD_W-1:0];
        div_quo_nxt = {div_quo_r[WORD_W-2:0], !div_diff[WORD_W]};
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(WORD_W - 1)) begin
          state_nxt = S_DFIN;
        end
      end

      S_DFIN: begin
        state_nxt = S_IDLE;
        load_out  = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = rd_sec_addr;
        mem_wdata = div_neg_r ? (~div_quo_r + WORD_W'(1)) : div_quo_r;
        depth_nxt = depth_r - DEPTH_W'(1);
        pc_nxt    = pc_r + pc_inc;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    o_npc_nxt    = NPC_W'(pc_nxt);
    o_halted_nxt = halt_nxt;

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      pc_r        <= pc_nxt;
      halt_r      <= halt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_tuser;
      opnd_r <= in_tdata[OPND_W-1:0];
    end
    div_rem_r <= div_rem_nxt;
    div_quo_r <= div_quo_nxt;
    div_den_r <= div_den_nxt;
    div_neg_r <= div_neg_nxt;
    div_cnt_r <= div_cnt_nxt;
    if (load_out) begin
      o_npc_r    <= o_npc_nxt;
      o_pvalid_r <= o_pvalid_nxt;
      o_pvalue_r <= o_pvalue_nxt;
      o_halted_r <= o_halted_nxt;
      o_fault_r  <= o_fault_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_pvalid_r;
  assign out_tdata  = OUT_TDATA_W'({o_fault_r, o_halted_r, o_pvalue_r, o_npc_r});

`ifndef NO_ASSERTIONS
  a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_EXEC)
    else $error("accepted request did not enter execute");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC || state_r == S_DFIN) |-> !out_valid_r)
    else $error("result register busy when a result is produced");

  a_depth_rng: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r && $stable(pc_r) && $stable(depth_r))
    else $error("state changed after halt");
`endif

endmodule
